### hdl/apdt_pkg.sv
// Shared types and constants for the adaptive pacing delay tuner.
// No dependencies; used by apdt_div and adaptive_pacing_delay_tuner_top.
package apdt_pkg;

  localparam int unsigned AIM_W   = 24;
  localparam int unsigned AVG_W   = 40;
  localparam int unsigned CYC_W   = 40;
  localparam int unsigned BAT_W   = 32;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned DVD_W   = CYC_W + FRAC_W;  // dividend width, 48
  localparam int unsigned DVS_W   = BAT_W;           // divisor width, 32
  localparam int unsigned STRK_W  = 6;
  localparam int unsigned LIM_W   = 5;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFGA_W  = 3;

  // register indexes on the config port
  localparam logic [CFGA_W-1:0] REG_TARGET_DELAY  = 3'd0;
  localparam logic [CFGA_W-1:0] REG_HOLD_TOL      = 3'd1;
  localparam logic [CFGA_W-1:0] REG_TIMER_UNC     = 3'd2;
  localparam logic [CFGA_W-1:0] REG_AIM_CEILING   = 3'd3;
  localparam logic [CFGA_W-1:0] REG_MAX_STREAK    = 3'd4;
  localparam logic [CFGA_W-1:0] REG_RAMP_DIVISOR  = 3'd5;

  typedef enum logic [1:0] {
    ACT_HOLD = 2'd0,
    ACT_DOWN = 2'd1,
    ACT_UP   = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  // sequencer -> divider controls
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

### hdl/apdt_div.sv
// Shared restoring divider, one quotient bit per step, MSB first.
// Depends on apdt_pkg (widths, div_ctrl_t).
module apdt_div
  import apdt_pkg::*;
(
  input  logic             clk,
  input  div_ctrl_t        ctrl,
  input  logic [DVD_W-1:0] load_dividend,
  input  logic [DVS_W-1:0] load_divisor,
  output logic [DVD_W-1:0] quo
);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W+1:0] diff;

  // shift next dividend bit into the partial remainder and try the subtract
  assign diff = {1'b0, rem, quo[DVD_W-1]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= '0;
      dvs <= load_divisor;
      quo <= load_dividend;
    end else if (ctrl.step) begin
      if (!diff[DVS_W+1]) begin
        rem <= diff[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DVS_W-2:0], quo[DVD_W-1]};
        quo <= {quo[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

### hdl/adaptive_pacing_delay_tuner_top.sv
// Adaptive pacing delay tuner, top level: config registers, sequencer, output stage.
// Depends on apdt_pkg and apdt_div.
//
//  channel | dir | handshake         | content
//  --------+-----+-------------------+------------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | one pass report: cycles, batches, start flag
//  m_*     | out | m_tvalid/m_tready | new aim, wait threshold, pass average, action
//  cfg_*   | in  | cfg_we            | register write, index cfg_addr, data cfg_data
//
//  Steps: a pass with nonzero batch count runs the divider for the average (ST_DIV),
//  compares in ST_CMP, runs the divider for the step exponent (ST_EXP), applies the
//  step in ST_APPLY and loads the output in ST_FINISH. Holds and zero-batch passes
//  finish sooner. The single shared divider yields one quotient bit per cycle while
//  it steps; s_tready is high only while the sequencer is idle.
//  Reset (rst, synchronous) loads register defaults and clears aim, streak, m_tvalid.
//  A stalled result waits in the output register; the next pass may be accepted
//  meanwhile and only waits at its final output load.
module adaptive_pacing_delay_tuner_top
  import apdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // pass reports
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [71:0]       s_tdata,   // [39:0] pass_cycles, [71:40] batch_count
  input  logic [0:0]        s_tuser,   // [0] start_run
  // results
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [87:0]       m_tdata,   // [23:0] new_aim, [47:24] wait_threshold,
                                       // [87:48] pass_average
  output logic [1:0]        m_tuser,   // [1:0] action
  // configuration
  input  logic              cfg_we,
  input  logic [CFGA_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CMP,
    ST_EXP,
    ST_APPLY,
    ST_FINISH
  } state_t;

  // config registers
  logic [AIM_W-1:0]  target_delay;
  logic [15:0]       hold_tolerance;
  logic [15:0]       timer_uncertainty;
  logic [AIM_W-1:0]  aim_ceiling;
  logic [LIM_W-1:0]  max_streak;
  logic [LIM_W-1:0]  ramp_divisor;

  // tuner state and per-pass work registers
  state_t                    state;
  logic [AIM_W-1:0]          aim;
  logic signed [STRK_W-1:0]  streak;
  logic [AVG_W-1:0]          avg;
  action_t                   action;
  logic [5:0]                cnt;

  // divider hookup
  div_ctrl_t         div_ctrl;
  logic [DVD_W-1:0]  div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic [DVD_W-1:0]  div_quo;

  logic                      in_beat;
  logic [CYC_W-1:0]          pass_cycles;
  logic [BAT_W-1:0]          batch_count;
  logic                      start_run;

  logic [AVG_W-1:0]          avg_sat;
  logic [31:0]               t_fix;
  logic                      in_band;
  logic                      too_slow;
  logic signed [STRK_W-1:0]  lim_s;
  logic signed [STRK_W-1:0]  streak_dn;
  logic signed [STRK_W-1:0]  streak_up;
  logic signed [STRK_W-1:0]  streak_new;
  logic [LIM_W-1:0]          streak_mag;
  logic                      do_step;
  logic [LIM_W-1:0]          ramp_eff;
  logic [31:0]               step_sz;
  logic [31:0]               aim_sum;
  logic [AIM_W-1:0]          aim_dn;
  logic [AIM_W-1:0]          aim_up;
  logic [AIM_W-1:0]          wait_thr;
  logic                      out_free;

  assign pass_cycles = s_tdata[39:0];
  assign batch_count = s_tdata[71:40];
  assign start_run   = s_tuser[0];

  assign s_tready = (state == ST_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // average saturates when quotient spills past 40 bits
  assign avg_sat = (div_quo[DVD_W-1:AVG_W] != '0) ? {AVG_W{1'b1}} : div_quo[AVG_W-1:0];

  // dead band compare, all widened so nothing wraps
  assign t_fix    = {target_delay, 8'h00};
  assign in_band  = (({1'b0, avg_sat} + 41'(hold_tolerance)) >= 41'(t_fix)) &&
                    (41'(avg_sat) <= (41'(t_fix) + 41'(hold_tolerance)));
  assign too_slow = (avg_sat > AVG_W'(t_fix));

  // streak update: a reversal zeroes it, otherwise it grows up to the limit
  assign lim_s = $signed({1'b0, max_streak});
  always_comb begin
    if (streak > 0)            streak_dn = '0;
    else if (streak > -lim_s)  streak_dn = streak - 6'sd1;
    else                       streak_dn = streak;
    if (streak < 0)            streak_up = '0;
    else if (streak < lim_s)   streak_up = streak + 6'sd1;
    else                       streak_up = streak;
  end

  assign do_step    = too_slow ? (aim != '0) : (aim < aim_ceiling);
  assign streak_new = too_slow ? streak_dn : streak_up;
  assign streak_mag = streak_new[STRK_W-1] ? LIM_W'(-streak_new) : streak_new[LIM_W-1:0];
  assign ramp_eff   = (ramp_divisor == '0) ? LIM_W'(1) : ramp_divisor;

  // divider feed: pass average on accept, step exponent from the compare cycle
  always_comb begin
    div_ctrl.load = 1'b0;
    div_ctrl.step = (state == ST_DIV) || (state == ST_EXP);
    div_dividend  = {pass_cycles, 8'h00};
    div_divisor   = batch_count;
    if (state == ST_IDLE) begin
      div_ctrl.load = in_beat && (batch_count != '0);
    end else if (state == ST_CMP) begin
      div_ctrl.load = !in_band && do_step;
      div_dividend  = {streak_mag, {(DVD_W-LIM_W){1'b0}}};
      div_divisor   = DVS_W'(ramp_eff);
    end
  end

  // exponent is at most 31, so the step fits in 32 bits
  assign step_sz = 32'd1 << div_quo[LIM_W-1:0];
  assign aim_sum = {8'h00, aim} + step_sz;
  assign aim_dn  = (step_sz >= {8'h00, aim}) ? '0 : (aim - step_sz[AIM_W-1:0]);
  assign aim_up  = (aim_sum > 32'(AIM_W'('1))) ? {AIM_W{1'b1}} : aim_sum[AIM_W-1:0];

  assign wait_thr = (aim > AIM_W'(timer_uncertainty)) ?
                    (aim - AIM_W'(timer_uncertainty)) : '0;

  apdt_div u_div (
    .clk           (clk),
    .ctrl          (div_ctrl),
    .load_dividend (div_dividend),
    .load_divisor  (div_divisor),
    .quo           (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target_delay      <= 24'd1000;
      hold_tolerance    <= 16'd256;
      timer_uncertainty <= 16'd40;
      aim_ceiling       <= 24'd1000000;
      max_streak        <= 5'd8;
      ramp_divisor      <= 5'd1;
      state             <= ST_IDLE;
      aim               <= '0;
      streak            <= '0;
      m_tvalid          <= 1'b0;
      cnt               <= '0;
      action            <= ACT_NONE;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_TARGET_DELAY: target_delay      <= cfg_data;
          REG_HOLD_TOL:     hold_tolerance    <= cfg_data[15:0];
          REG_TIMER_UNC:    timer_uncertainty <= cfg_data[15:0];
          REG_AIM_CEILING:  aim_ceiling       <= cfg_data;
          REG_MAX_STREAK:   max_streak        <= cfg_data[LIM_W-1:0];
          REG_RAMP_DIVISOR: ramp_divisor      <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end

      // the finish state reloads m_tvalid itself
      if (m_tvalid && m_tready && state != ST_FINISH) m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            if (start_run) begin
              aim    <= target_delay;
              streak <= '0;
            end
            if (batch_count == '0) begin
              avg    <= '0;
              action <= ACT_NONE;
              state  <= ST_FINISH;
            end else begin
              cnt   <= 6'(DVD_W - 1);
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (cnt == '0) state <= ST_CMP;
          else           cnt   <= cnt - 6'd1;
        end
        ST_CMP: begin
          avg <= avg_sat;
          if (in_band || !do_step) begin
            action <= ACT_HOLD;
            state  <= ST_FINISH;
          end else begin
            streak <= streak_new;
            action <= too_slow ? ACT_DOWN : ACT_UP;
            cnt    <= 6'(LIM_W - 1);
            state  <= ST_EXP;
          end
        end
        ST_EXP: begin
          if (cnt == '0) state <= ST_APPLY;
          else           cnt   <= cnt - 6'd1;
        end
        ST_APPLY: begin
          aim   <= (action == ACT_DOWN) ? aim_dn : aim_up;
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            m_tdata  <= {avg, wait_thr, aim};
            m_tuser  <= action;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // aim moves only on a start_run reload or in the apply cycle
  a_aim_moves: assert property (@(posedge clk) disable iff (rst)
    (state != ST_APPLY && !in_beat) |=> $stable(aim))
    else $error("aim changed outside accept/apply");

  // a new result only comes from the finish state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside finish");

  // streak stays within -31..31
  a_streak_rng: assert property (@(posedge clk) disable iff (rst)
    streak != -6'sd32)
    else $error("streak out of range");

  // no-update results carry a zero average
  a_none_avg: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ACT_NONE) |-> m_tdata[87:48] == '0)
    else $error("no-update result with nonzero average");

  // threshold never exceeds the aim
  a_thr_le_aim: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[47:24] <= m_tdata[23:0])
    else $error("wait threshold above aim");

endmodule

### tb/adaptive_pacing_delay_tuner_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for adaptive_pacing_delay_tuner_top: directed table, then random
// passes under several register settings. Needs apdt_pkg and the tuner RTL only.
module adaptive_pacing_delay_tuner_top_test;
  import apdt_pkg::*;

  localparam int RUN_LIMIT    = 600000;  // cycles before the watchdog gives up
  localparam int DRAIN_CYCLES = 100;     // exceeds the accept-to-result latency
  localparam int LONG_HOLD    = 400;     // sink back-pressure stretch
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 95;

  localparam logic [CYC_W-1:0] CYC_ALL = {CYC_W{1'b1}};
  localparam logic [BAT_W-1:0] BAT_ALL = {BAT_W{1'b1}};
  localparam longint unsigned  AVG_SAT = (64'd1 << AVG_W) - 1;
  localparam longint unsigned  AIM_SAT = (64'd1 << AIM_W) - 1;

  // one result beat as the tuner reports it
  typedef struct packed {
    logic [AIM_W-1:0] aim;
    logic [AIM_W-1:0] thr;
    logic [AVG_W-1:0] avg;
    action_t          act;
  } tuning_t;

  // directed stimulus row: a pass report or a register write
  typedef struct packed {
    bit                is_reg;
    bit                start;
    bit [CYC_W-1:0]    cyc;
    bit [BAT_W-1:0]    bat;
    logic [CFGA_W-1:0] idx;
    bit [CFG_W-1:0]    val;
    bit                typed;   // want is filled in by hand
    tuning_t           want;
  } plan_row_t;

  // direction bias of random pass averages relative to the target
  typedef enum int {DRIFT_BAND, DRIFT_SLOW, DRIFT_FAST, DRIFT_MIXED} drift_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [71:0]       s_tdata  = '0;
  logic [0:0]        s_tuser  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [87:0]       m_tdata;
  logic [1:0]        m_tuser;
  logic              cfg_we   = 1'b0;
  logic [CFGA_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  adaptive_pacing_delay_tuner_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow registers, reset values
  bit [23:0] cfg_target  = 24'd1000;
  bit [15:0] cfg_tol     = 16'd256;
  bit [15:0] cfg_unc     = 16'd40;
  bit [23:0] cfg_ceiling = 24'd1000000;
  bit [4:0]  cfg_lim     = 5'd8;
  bit [4:0]  cfg_ramp    = 5'd1;

  // shadow tuner state
  bit [AIM_W-1:0] aim_m    = '0;
  int             streak_m = 0;

  tuning_t   tuning_due[$];   // results owed by the tuner, oldest first
  plan_row_t plan[$];
  int        mismatches = 0;
  bit        idling_on = 1'b1;
  bit        sink_block_req = 1'b0;
  int        sink_hold = 0;
  int        cycle_count = 0;
  drift_t    drift = DRIFT_MIXED;
  tuning_t   got_beat;
  tuning_t   due_beat;

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned pace_step(input int s);
    int unsigned mag;
    int unsigned dv;
    mag = (s < 0) ? -s : s;
    dv  = (cfg_ramp == 0) ? 1 : 32'(cfg_ramp);  // zero divisor acts as one
    return 64'd1 << ((mag / dv) & 63);
  endfunction

  // Updates aim/streak for one accepted pass and returns the beat it must produce.
  function automatic tuning_t tune_pass(input bit start, input bit [CYC_W-1:0] cyc,
                                        input bit [BAT_W-1:0] bat);
    tuning_t         r;
    longint unsigned avg;
    longint unsigned t;
    longint unsigned tol;
    longint unsigned st;
    longint unsigned sum;
    bit              in_band;
    avg   = '0;
    r.act = ACT_NONE;
    if (start) begin
      aim_m    = cfg_target;
      streak_m = 0;
    end
    if (bat != 0) begin
      t   = longint'(cfg_target) << FRAC_W;
      tol = 64'(cfg_tol);
      avg = (longint'(cyc) << FRAC_W) / longint'(bat);
      if (avg > AVG_SAT) avg = AVG_SAT;
      r.act   = ACT_HOLD;
      in_band = (avg + tol >= t) && (avg <= t + tol);
      if (!in_band && avg > t) begin
        // too slow: shorten the aim, unless already at zero
        if (aim_m != 0) begin
          if (streak_m > 0) streak_m = 0;
          else if (streak_m > -int'(cfg_lim)) streak_m--;
          st    = pace_step(streak_m);
          aim_m = (st >= longint'(aim_m)) ? '0 : aim_m - st[AIM_W-1:0];
          r.act = ACT_DOWN;
        end
      end else if (!in_band) begin
        // too fast: lengthen the aim while under the ceiling
        if (aim_m < cfg_ceiling) begin
          if (streak_m < 0) streak_m = 0;
          else if (streak_m < int'(cfg_lim)) streak_m++;
          sum   = longint'(aim_m) + pace_step(streak_m);
          aim_m = (sum > AIM_SAT) ? AIM_SAT[AIM_W-1:0] : sum[AIM_W-1:0];
          r.act = ACT_UP;
        end
      end
    end
    r.aim = aim_m;
    r.thr = (aim_m > cfg_unc) ? aim_m - AIM_W'(cfg_unc) : '0;
    r.avg = avg[AVG_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- directed table

  function automatic void plan_pass(input bit start, input bit [CYC_W-1:0] cyc,
                                    input bit [BAT_W-1:0] bat);
    plan_row_t r;
    r        = '0;
    r.start  = start;
    r.cyc    = cyc;
    r.bat    = bat;
    plan.push_back(r);
  endfunction

  function automatic void plan_check(input bit start, input bit [CYC_W-1:0] cyc,
                                     input bit [BAT_W-1:0] bat, input bit [AIM_W-1:0] aim,
                                     input bit [AIM_W-1:0] thr, input bit [AVG_W-1:0] avg,
                                     input action_t act);
    plan_row_t r;
    r          = '0;
    r.start    = start;
    r.cyc      = cyc;
    r.bat      = bat;
    r.typed    = 1'b1;
    r.want.aim = aim;
    r.want.thr = thr;
    r.want.avg = avg;
    r.want.act = act;
    plan.push_back(r);
  endfunction

  function automatic void plan_reg(input logic [CFGA_W-1:0] idx, input bit [CFG_W-1:0] val);
    plan_row_t r;
    r        = '0;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    plan.push_back(r);
  endfunction

  // ---------------------------------------------------------------- drivers

  // source side: optional idle burst, then hold the beat until it is taken
  task automatic send_pass(input bit start, input bit [CYC_W-1:0] cyc,
                           input bit [BAT_W-1:0] bat, input bit typed, input tuning_t want);
    tuning_t guess;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = start;
    s_tdata  = {bat, cyc};
    do @(posedge clk); while (!s_tready);
    guess = tune_pass(start, cyc, bat);
    tuning_due.push_back(typed ? want : guess);
    @(negedge clk);
  endtask

  // stop offering and wait for every owed beat
  task automatic settle();
    s_tvalid = 1'b0;
    while (tuning_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFGA_W-1:0] idx, input bit [CFG_W-1:0] val);
    cfg_we   = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we   = 1'b0;
    case (idx)
      REG_TARGET_DELAY: cfg_target  = val[23:0];
      REG_HOLD_TOL:     cfg_tol     = val[15:0];
      REG_TIMER_UNC:    cfg_unc     = val[15:0];
      REG_AIM_CEILING:  cfg_ceiling = val[23:0];
      REG_MAX_STREAK:   cfg_lim     = val[4:0];
      REG_RAMP_DIVISOR: cfg_ramp    = val[4:0];
      default: ;
    endcase
  endtask

  task automatic random_config();
    bit [23:0] tgt;
    bit [23:0] ceil_v;
    bit [15:0] tol;
    bit [15:0] unc;
    bit [4:0]  lim;
    bit [4:0]  ramp;
    case ($urandom_range(0, 6))
      0: tgt = '0;
      1: tgt = 24'hFFFFFF;
      2: tgt = 24'($urandom_range(1, 64));
      3: tgt = 24'($urandom());
      default: tgt = 24'($urandom_range(100, 5000));
    endcase
    case ($urandom_range(0, 5))
      0: tol = '0;
      1: tol = 16'hFFFF;
      2: tol = 16'($urandom());
      default: tol = 16'($urandom_range(1, 2048));
    endcase
    case ($urandom_range(0, 4))
      0: unc = '0;
      1: unc = 16'hFFFF;
      default: unc = 16'($urandom_range(0, 200));
    endcase
    case ($urandom_range(0, 7))
      0: ceil_v = '0;
      1, 2: ceil_v = 24'hFFFFFF;
      3: ceil_v = 24'($urandom());
      default: ceil_v = (tgt > 24'hFFFFFF - 4000) ? 24'hFFFFFF :
                        24'(tgt + $urandom_range(0, 4000));
    endcase
    case ($urandom_range(0, 4))
      0: lim = '0;
      1: lim = 5'd31;
      default: lim = 5'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 4))
      0: ramp = 5'd31;
      1: ramp = 5'($urandom_range(1, 31));
      default: ramp = 5'($urandom_range(1, 4));
    endcase
    write_reg(REG_TARGET_DELAY, tgt);
    write_reg(REG_HOLD_TOL, CFG_W'(tol));
    write_reg(REG_TIMER_UNC, CFG_W'(unc));
    write_reg(REG_AIM_CEILING, ceil_v);
    write_reg(REG_MAX_STREAK, CFG_W'(lim));
    write_reg(REG_RAMP_DIVISOR, CFG_W'(ramp));
  endtask

  // Mostly averages aimed around the band so streaks build up; some raw noise.
  task automatic random_pass(output bit start, output bit [CYC_W-1:0] cyc,
                             output bit [BAT_W-1:0] bat);
    longint t;
    longint band;
    longint mag;
    longint avg_aim;
    longint prod;
    drift_t way;
    int     pick;
    start = ($urandom_range(0, 31) == 0);
    if ($urandom_range(0, 7) == 0) drift = drift_t'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      bat = '0;
      cyc = CYC_W'({$urandom(), $urandom()});
    end else if (pick < 15) begin
      bat = $urandom();
      cyc = CYC_W'({$urandom(), $urandom()});
    end else begin
      case ($urandom_range(0, 5))
        0, 1, 2: bat = $urandom_range(1, 16);
        3, 4: bat = $urandom_range(1, 4096);
        default: bat = $urandom_range(1, 65535);
      endcase
      t    = longint'(cfg_target) << FRAC_W;
      band = longint'(cfg_tol);
      way  = drift;
      if (way == DRIFT_MIXED) way = drift_t'($urandom_range(0, 2));
      if ($urandom_range(0, 2) == 0) mag = longint'($urandom_range(0, 255));
      else mag = longint'($urandom()) % (t / 2 + 1);
      case (way)
        DRIFT_SLOW: avg_aim = t + band + 1 + mag;
        DRIFT_FAST: avg_aim = t - band - 1 - mag;
        default: avg_aim = t - band + longint'($urandom()) % (2 * band + 1);
      endcase
      if (avg_aim < 0) avg_aim = 0;
      prod = (avg_aim * longint'(bat)) >>> FRAC_W;
      cyc  = (prod > longint'(CYC_ALL)) ? CYC_ALL : prod[CYC_W-1:0];
    end
  endtask

  // ---------------------------------------------------------------- sink and checker

  // Sink ready: random stalls, plus one long hold requested by the stimulus.
  always @(negedge clk) begin
    if (sink_block_req) begin
      sink_block_req = 1'b0;
      sink_hold      = LONG_HOLD;
    end
    if (sink_hold != 0) begin
      m_tready  = 1'b0;
      sink_hold = sink_hold - 1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      m_tready  = 1'b0;
      sink_hold = $urandom_range(0, 10);
    end else begin
      m_tready = 1'b1;
    end
  end

  task automatic flag_result(input string why, input tuning_t want, input tuning_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: aim %0h/%0h thr %0h/%0h avg %0h/%0h action %0d/%0d (expected/actual)",
               why, want.aim, got.aim, want.thr, got.thr, want.avg, got.avg,
               want.act, got.act);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_beat.aim = m_tdata[23:0];
      got_beat.thr = m_tdata[47:24];
      got_beat.avg = m_tdata[87:48];
      got_beat.act = action_t'(m_tuser);
      if (tuning_due.size() == 0) begin
        flag_result("result with no pass pending", '0, got_beat);
      end else begin
        due_beat = tuning_due.pop_front();
        if (got_beat.aim !== due_beat.aim || got_beat.thr !== due_beat.thr ||
            got_beat.avg !== due_beat.avg || got_beat.act !== due_beat.act)
          flag_result("result mismatch", due_beat, got_beat);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    int                ph;
    bit                st;
    bit [CYC_W-1:0]    cy;
    bit [BAT_W-1:0]    ba;

    // defaults after reset: target 1000 (256000 in fixed point), band +-256, aim 0
    plan_check(1'b0, '0, '0, 24'd0, 24'd0, 40'd0, ACT_NONE);          // zero batches
    plan_check(1'b0, 40'd1000, 32'd1, 24'd0, 24'd0, 40'd256000, ACT_HOLD);
    plan_check(1'b0, 40'd2000, 32'd1, 24'd0, 24'd0, 40'd512000, ACT_HOLD); // slow, aim at 0
    plan_check(1'b1, 40'd1000, 32'd1, 24'd1000, 24'd960, 40'd256000, ACT_HOLD);
    plan_check(1'b0, 40'd500, 32'd1, 24'd1002, 24'd962, 40'd128000, ACT_UP);
    plan_check(1'b0, 40'd500, 32'd1, 24'd1006, 24'd966, 40'd128000, ACT_UP);
    // band edges; with 256 batches the average equals the cycle count
    plan_pass(1'b0, 40'd256256, 32'd256);
    plan_pass(1'b0, 40'd255744, 32'd256);
    plan_pass(1'b0, 40'd256257, 32'd256);
    plan_pass(1'b0, 40'd255743, 32'd256);
    plan_pass(1'b0, CYC_ALL, 32'd1);                                   // average saturates
    plan_pass(1'b0, CYC_ALL, BAT_ALL);
    plan_pass(1'b0, '0, BAT_ALL);
    plan_check(1'b1, 40'd77, '0, 24'd1000, 24'd960, 40'd0, ACT_NONE);  // reload, no update
    plan_reg(REG_AIM_CEILING, 24'd1000);
    plan_check(1'b0, '0, 32'd1, 24'd1000, 24'd960, 40'd0, ACT_HOLD);   // at ceiling
    // aim saturation at the top
    plan_reg(REG_TARGET_DELAY, 24'hFFFFFA);
    plan_reg(REG_AIM_CEILING, 24'hFFFFFF);
    plan_reg(REG_MAX_STREAK, 24'd31);
    plan_pass(1'b1, '0, 32'd1);
    plan_pass(1'b0, '0, 32'd1);
    // floor at zero, threshold floored
    plan_reg(REG_TARGET_DELAY, 24'd5);
    plan_reg(REG_TIMER_UNC, 24'hFFFF);
    plan_pass(1'b1, CYC_ALL, 32'd1);
    plan_pass(1'b0, CYC_ALL, 32'd1);
    // zero ramp divisor, zero band, then a streak left above a lowered limit
    plan_reg(REG_TARGET_DELAY, 24'd3000);
    plan_reg(REG_HOLD_TOL, 24'd0);
    plan_reg(REG_TIMER_UNC, 24'd0);
    plan_reg(REG_RAMP_DIVISOR, 24'd0);
    plan_pass(1'b1, '0, 32'd1);
    plan_reg(REG_RAMP_DIVISOR, 24'd1);
    plan_pass(1'b0, '0, 32'd1);
    plan_pass(1'b0, '0, 32'd1);
    plan_pass(1'b0, '0, 32'd1);
    plan_reg(REG_MAX_STREAK, 24'd2);
    plan_pass(1'b0, '0, 32'd1);                                        // streak stays at 4
    plan_pass(1'b0, CYC_ALL, 32'd1);                                   // direction flips

    repeat (3) @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_pass(plan[i].start, plan[i].cyc, plan[i].bat, plan[i].typed, plan[i].want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      random_config();
      if (ph == 1) sink_block_req = 1'b1;     // fill the tuner and stall its input
      if (ph == PHASES - 1) idling_on = 1'b0;
      repeat (PHASE_ITEMS) begin
        random_pass(st, cy, ba);
        send_pass(st, cy, ba, 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && tuning_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
hdl/apdt_pkg.sv
hdl/apdt_div.sv
hdl/adaptive_pacing_delay_tuner_top.sv
tb/adaptive_pacing_delay_tuner_top_test.sv
